// ===== hw/rtl/hsp_pkg.sv =====
// Shared types and constants for the puzzle-state shortest path block.
`default_nettype none

package hsp_pkg;

  localparam int unsigned IDX_W = 7;
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned SW = 4;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_BAD,
    OP_LOAD,
    OP_INIT,
    OP_JNEXT,
    OP_JREAD,
    OP_JLOAD,
    OP_KNEXT,
    OP_KREAD,
    OP_KUPD,
    OP_PSTART,
    OP_LREAD,
    OP_LLOAD,
    OP_FSTART,
    OP_FWRITE,
    OP_FLOAD,
    OP_EREAD,
    OP_EOUT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_JCHK,
    ST_JWAIT,
    ST_KSCAN,
    ST_KWAIT,
    ST_PATH,
    ST_LCHK,
    ST_LWAIT,
    ST_FCHK,
    ST_FWAIT,
    ST_ERD,
    ST_EOUT
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic bad_in;
    logic j_reached;
    logic j_last;
    logic k_last;
    logic joined;
    logic stop;
    logic has_pred_v;
    logic len_lt;
    logic pos_zero;
    logic i_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hanoi_state_shortest_path.sv =====
// Top level of the shortest path search between two puzzle configurations.
//
// A request is taken at a rising clock edge with start_i high and busy_o low;
// start_state_i and goal_state_i are sampled then. If either index is out of
// range, one result with bad_request_o set follows in the next cycle.
// Otherwise the block runs relaxation sweeps over all state pairs: for each
// reached row it reads the row's distance and scans every pair of the row,
// reading and relaxing each joined pair, and it skips each row not yet
// reached. Sweeps repeat until one changes nothing, at most STATES - 1 sweeps
// in all. The path is then walked twice through the predecessor memory and
// emitted from the start state, each result marked by valid_o for a single
// cycle; last_o marks the goal. The receiver cannot stall the block.
// busy_o stays high from the request until the last result is on the ports.
// Reset returns the block to idle with no pending results.
`default_nettype none

module hanoi_state_shortest_path
  import hsp_pkg::*;
#(
  parameter int unsigned DISKS  = 4,
  parameter int unsigned PEGS   = 3,
  parameter int unsigned STATES = 81
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [IDX_W-1:0] start_state_i,
  input  wire logic [IDX_W-1:0] goal_state_i,
  output logic                  busy_o,
  output logic                  valid_o,
  output logic      [IDX_W-1:0] path_state_o,
  output logic                  last_o,
  output logic                  bad_request_o
);

  cmd_t  cmd;
  stat_t stat;

  hsp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  hsp_dp #(.DISKS(DISKS), .PEGS(PEGS), .STATES(STATES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .start_state_i (start_state_i),
    .goal_state_i  (goal_state_i),
    .stat_o        (stat),
    .valid_o       (valid_o),
    .path_state_o  (path_state_o),
    .last_o        (last_o),
    .bad_request_o (bad_request_o)
  );

`ifndef SYNTHESIS
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && bad_request_o |-> last_o)
    else $error("Rejected request result is not marked last.");

  a_last_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy_o)
    else $error("Final result shown while the block is still busy.");

  a_request_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(start_i && !busy_o) |-> busy_o || (valid_o && bad_request_o))
    else $error("Accepted request neither started a search nor was rejected.");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/hsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hsp_ctrl.sv =====
// Controller state machine that sequences the relaxation sweeps and the path output.
`default_nettype none

module hsp_ctrl
  import hsp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && !stat_i.bad_in) state_d = ST_INIT;
      end
      ST_INIT: state_d = ST_JCHK;
      ST_JCHK: begin
        if (stat_i.j_reached) state_d = ST_JWAIT;
        else if (stat_i.j_last && stat_i.stop) state_d = ST_PATH;
      end
      ST_JWAIT: state_d = ST_KSCAN;
      ST_KSCAN: begin
        if (stat_i.joined) state_d = ST_KWAIT;
        else if (stat_i.k_last) state_d = (stat_i.j_last && stat_i.stop) ? ST_PATH : ST_JCHK;
      end
      ST_KWAIT: begin
        if (stat_i.k_last) state_d = (stat_i.j_last && stat_i.stop) ? ST_PATH : ST_JCHK;
        else state_d = ST_KSCAN;
      end
      ST_PATH: state_d = ST_LCHK;
      ST_LCHK: state_d = (stat_i.has_pred_v && stat_i.len_lt) ? ST_LWAIT : ST_FCHK;
      ST_LWAIT: state_d = ST_LCHK;
      ST_FCHK: begin
        if (stat_i.pos_zero) state_d = ST_ERD;
        else if (stat_i.has_pred_v) state_d = ST_FWAIT;
      end
      ST_FWAIT: state_d = ST_FCHK;
      ST_ERD: state_d = ST_EOUT;
      ST_EOUT: state_d = stat_i.i_last ? ST_IDLE : ST_ERD;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_IDLE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) cmd_o.op = stat_i.bad_in ? OP_BAD : OP_LOAD;
      end
      ST_INIT: cmd_o.op = OP_INIT;
      ST_JCHK: cmd_o.op = stat_i.j_reached ? OP_JREAD : OP_JNEXT;
      ST_JWAIT: cmd_o.op = OP_JLOAD;
      ST_KSCAN: cmd_o.op = stat_i.joined ? OP_KREAD : OP_KNEXT;
      ST_KWAIT: cmd_o.op = OP_KUPD;
      ST_PATH: cmd_o.op = OP_PSTART;
      ST_LCHK: cmd_o.op = (stat_i.has_pred_v && stat_i.len_lt) ? OP_LREAD : OP_FSTART;
      ST_LWAIT: cmd_o.op = OP_LLOAD;
      ST_FCHK: cmd_o.op = OP_FWRITE;
      ST_FWAIT: cmd_o.op = OP_FLOAD;
      ST_ERD: cmd_o.op = OP_EREAD;
      ST_EOUT: cmd_o.op = OP_EOUT;
      default: cmd_o.op = OP_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/hsp_dp.sv =====
// Datapath with state counters, distance, predecessor and path memories, and output registers.
`default_nettype none

module hsp_dp
  import hsp_pkg::*;
#(
  parameter int unsigned DISKS  = 4,
  parameter int unsigned PEGS   = 3,
  parameter int unsigned STATES = 81
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  input  wire logic [IDX_W-1:0] start_state_i,
  input  wire logic [IDX_W-1:0] goal_state_i,
  output stat_t                 stat_o,
  output logic                  valid_o,
  output logic      [IDX_W-1:0] path_state_o,
  output logic                  last_o,
  output logic                  bad_request_o
);

  localparam int unsigned AW = $clog2(STATES);
  localparam int unsigned PW = $clog2(PEGS);
  localparam int unsigned LW = $clog2(STATES + 1);

  typedef logic [DISKS-1:0][PW-1:0] dig_t;

  function automatic dig_t inc_digits(input dig_t x);
    dig_t r;
    logic c;
    r = x;
    c = 1'b1;
    for (int d = 0; d < DISKS; d++) begin
      if (c) begin
        if (x[d] == PW'(PEGS - 1)) begin
          r[d] = '0;
        end else begin
          r[d] = x[d] + PW'(1);
          c = 1'b0;
        end
      end
    end
    return r;
  endfunction

  logic [AW-1:0]     s_q, g_q, j_q, k_q, sweep_q, dj_q, v_q;
  dig_t              jd_q, kd_q;
  logic              changed_q;
  logic [STATES-1:0] reached_q, haspred_q;
  logic [LW-1:0]     len_q, pos_q;
  logic [SW-1:0]     i_q;

  logic [AW-1:0] dist_rdata, pred_rdata, stack_rdata, dist_raddr, dist_waddr, dist_wdata;
  logic          dist_we, pred_we, stack_we;
  logic [AW:0]   nd;
  logic          improve, upd, joined;
  logic [DISKS-1:0] diff, blk;

  always_comb begin
    for (int d = 0; d < DISKS; d++) begin
      diff[d] = (jd_q[d] != kd_q[d]);
      blk[d] = 1'b0;
      for (int e = 0; e < DISKS; e++) begin
        if (e < d && (jd_q[e] == jd_q[d] || kd_q[e] == kd_q[d])) blk[d] = 1'b1;
      end
    end
    joined = $onehot(diff) && !(|(diff & blk));
  end

  assign nd      = {1'b0, dj_q} + (AW + 1)'(1);
  assign improve = !reached_q[k_q] || (nd < {1'b0, dist_rdata});
  assign upd     = (cmd_i.op == OP_KUPD) && improve;

  assign stat_o.bad_in     = (32'(start_state_i) >= STATES) || (32'(goal_state_i) >= STATES);
  assign stat_o.j_reached  = reached_q[j_q];
  assign stat_o.j_last     = (j_q == AW'(STATES - 1));
  assign stat_o.k_last     = (k_q == AW'(STATES - 1));
  assign stat_o.joined     = joined;
  assign stat_o.stop       = !(changed_q || upd) || (sweep_q == AW'(STATES - 2));
  assign stat_o.has_pred_v = haspred_q[v_q];
  assign stat_o.len_lt     = (32'(len_q) < STATES);
  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.i_last     = (i_q == SW'(STACK_DEPTH - 1)) || (32'(i_q) + 1 == 32'(len_q));

  assign dist_raddr = (cmd_i.op == OP_JREAD) ? j_q : k_q;
  assign dist_we    = (cmd_i.op == OP_INIT) || upd;
  assign dist_waddr = (cmd_i.op == OP_INIT) ? s_q : k_q;
  assign dist_wdata = (cmd_i.op == OP_INIT) ? '0 : AW'(nd);
  assign pred_we    = upd;
  assign stack_we   = (cmd_i.op == OP_FWRITE) && (32'(pos_q) < STACK_DEPTH);

  hsp_ram #(.WIDTH(AW), .DEPTH(STATES)) u_dist (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  hsp_ram #(.WIDTH(AW), .DEPTH(STATES)) u_pred (
    .clk_i   (clk_i),
    .we_i    (pred_we),
    .waddr_i (k_q),
    .wdata_i (j_q),
    .raddr_i (v_q),
    .rdata_o (pred_rdata)
  );

  hsp_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (SW'(pos_q)),
    .wdata_i (v_q),
    .raddr_i (i_q),
    .rdata_o (stack_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0; g_q <= '0; j_q <= '0; k_q <= '0; sweep_q <= '0; dj_q <= '0; v_q <= '0;
      jd_q <= '0; kd_q <= '0; changed_q <= 1'b0;
      reached_q <= '0; haspred_q <= '0;
      len_q <= '0; pos_q <= '0; i_q <= '0;
      valid_o <= 1'b0; path_state_o <= '0; last_o <= 1'b0; bad_request_o <= 1'b0;
    end else begin
      valid_o <= (cmd_i.op == OP_EOUT) || (cmd_i.op == OP_BAD);
      unique case (cmd_i.op)
        OP_BAD: begin
          path_state_o  <= '0;
          last_o        <= 1'b1;
          bad_request_o <= 1'b1;
        end
        OP_LOAD: begin
          s_q <= AW'(start_state_i);
          g_q <= AW'(goal_state_i);
          reached_q <= {{(STATES - 1){1'b0}}, 1'b1} << start_state_i;
          haspred_q <= '0;
          j_q <= '0; jd_q <= '0; k_q <= '0; kd_q <= '0;
          sweep_q <= '0; changed_q <= 1'b0;
        end
        OP_JNEXT, OP_KNEXT, OP_KUPD: begin
          if (upd) begin
            reached_q[k_q] <= 1'b1;
            haspred_q[k_q] <= 1'b1;
          end
          if (cmd_i.op == OP_JNEXT || stat_o.k_last) begin
            k_q <= '0;
            kd_q <= '0;
            if (stat_o.j_last) begin
              j_q <= '0;
              jd_q <= '0;
              sweep_q <= sweep_q + AW'(1);
              changed_q <= 1'b0;
            end else begin
              j_q <= j_q + AW'(1);
              jd_q <= inc_digits(jd_q);
              changed_q <= changed_q || upd;
            end
          end else begin
            k_q <= k_q + AW'(1);
            kd_q <= inc_digits(kd_q);
            changed_q <= changed_q || upd;
          end
        end
        OP_JLOAD: begin
          dj_q <= dist_rdata;
          k_q <= '0;
          kd_q <= '0;
        end
        OP_PSTART: begin
          v_q <= g_q;
          len_q <= LW'(1);
        end
        OP_LLOAD: begin
          v_q <= pred_rdata;
          len_q <= len_q + LW'(1);
        end
        OP_FSTART: begin
          v_q <= g_q;
          pos_q <= len_q - LW'(1);
          i_q <= '0;
        end
        OP_FWRITE: begin
          if (!stat_o.pos_zero && !haspred_q[v_q]) pos_q <= pos_q - LW'(1);
        end
        OP_FLOAD: begin
          v_q <= pred_rdata;
          pos_q <= pos_q - LW'(1);
        end
        OP_EOUT: begin
          path_state_o  <= IDX_W'(stack_rdata);
          last_o        <= (32'(i_q) + 1 == 32'(len_q));
          bad_request_o <= 1'b0;
          i_q <= i_q + SW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
